### hdl/ipv6hp_pkg.sv
// ============================================================================
// ipv6hp_pkg
// Shared types and constants for the IPv6 header chain parser.
// ============================================================================
package ipv6hp_pkg;

    localparam int OFFSET_WIDTH = 17;
    localparam logic [OFFSET_WIDTH-1:0] OFF_MAX = {OFFSET_WIDTH{1'b1}};

    localparam logic [7:0] T_HOP     = 8'd0;
    localparam logic [7:0] T_ROUTING = 8'd43;
    localparam logic [7:0] T_FRAG    = 8'd44;
    localparam logic [7:0] T_AH      = 8'd51;
    localparam logic [7:0] T_DEST    = 8'd60;

    localparam logic [2:0] K_BASE    = 3'd0;
    localparam logic [2:0] K_EXT     = 3'd5;
    localparam logic [2:0] K_FRAG    = 3'd6;
    localparam logic [2:0] K_SUMMARY = 3'd7;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    typedef enum logic [2:0] {
        PH_FIXED   = 3'd0,
        PH_EXT0    = 3'd1,
        PH_EXT1    = 3'd2,
        PH_BODY    = 3'd3,
        PH_PAYLOAD = 3'd4
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       packet_end;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  record_kind;
        logic [63:0] record_value;
        logic        last_of_run;
    } out_word_t;

    // up to two records caused by one byte
    typedef struct packed {
        logic      two;
        out_word_t rec0;
        out_word_t rec1;
    } job_t;

    function automatic logic [11:0] header_len(input logic [7:0] t, input logic [7:0] len);
        logic [11:0] r;
        begin
            if (t == T_FRAG) begin
                r = 12'd8;
            end else if (t == T_AH) begin
                r = ({4'd0, len} + 12'd2) << 2;
            end else begin
                r = ({4'd0, len} + 12'd1) << 3;
            end
            return r;
        end
    endfunction

endpackage

### hdl/ipv6_header_chain_parser_top.sv
// ============================================================================
// ipv6_header_chain_parser_top
// IPv6 header chain parser: bytes in, tagged header records out.
// ============================================================================
// One packet byte is accepted per cycle while input ready is high; the chain
// walker is combinational, so bytes go back to back. A byte may cause up to two
// records, which leave one word per cycle while the receiver is ready, through a
// four-entry queue. Input ready drops only when the queue is nearly full.
module ipv6_header_chain_parser_top
    import ipv6hp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    logic fq_valid, fq_ready, qb_valid, qb_ready;
    job_t fq_job, qb_job;

    ipv6hp_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_valid), .in_word(s_data), .in_ready(s_ready),
        .job_valid(fq_valid), .job(fq_job), .job_ready(fq_ready)
    );

    ipv6hp_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .wr_valid(fq_valid), .wr_job(fq_job), .wr_ready(fq_ready),
        .rd_valid(qb_valid), .rd_job(qb_job), .rd_ready(qb_ready)
    );

    ipv6hp_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .job_valid(qb_valid), .job(qb_job), .job_ready(qb_ready),
        .m_valid(m_valid), .m_data(m_data), .m_ready(m_ready)
    );

endmodule

### hdl/ipv6hp_front.sv
// ============================================================================
// ipv6hp_front
// Walks the header chain one byte per cycle while the queue has room, and builds the records of a byte.
// ============================================================================
module ipv6hp_front
    import ipv6hp_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    input  in_word_t in_word,
    output logic     in_ready,
    output logic     job_valid,
    output job_t     job,
    input  logic     job_ready
);

    logic [OFFSET_WIDTH-1:0] pos_reg, pos_next;
    phase_t                  phase_reg, phase_next;
    logic [7:0]              pnh_reg, pnh_next;
    logic [7:0]              ext_type_reg, ext_type_next;
    logic [11:0]             left_reg, left_next;
    logic [OFFSET_WIDTH-1:0] start_reg, start_next;
    logic [63:0]             shift_reg, shift_next;
    logic [7:0]              count_reg, count_next;
    logic                    sent_reg, sent_next;

    logic        n0, n1;
    out_word_t   r0, r1;
    logic        take;
    logic [7:0]  b;
    logic [11:0] left_dec;
    logic [7:0]  nh;
    logic [7:0]  cnt_inc;
    logic [OFFSET_WIDTH-1:0] pos_inc;
    logic        walk;
    logic        have;

    assign in_ready = job_ready;
    assign take = in_valid && in_ready;
    assign b = in_word.data_byte;

    always_comb begin
        pos_inc = (pos_reg == OFF_MAX) ? OFF_MAX : pos_reg + 1'b1;
    end

    // add one record into the first free slot
    function automatic void put(inout logic f0, inout logic f1, inout out_word_t a,
                                inout out_word_t c, input logic [2:0] k,
                                input logic [63:0] v);
        out_word_t w;
        begin
            w.record_kind = k;
            w.record_value = v;
            w.last_of_run = 1'b0;
            if (!f0) begin
                a = w;
                f0 = 1'b1;
            end else if (!f1) begin
                c = w;
                f1 = 1'b1;
            end
        end
    endfunction

    function automatic logic [63:0] summ(input logic [7:0] p, input logic [OFFSET_WIDTH-1:0] s,
                                         input logic [7:0] c, input logic st);
        logic [63:0] v;
        logic [19:0] s20;
        begin
            s20 = 20'(s);
            v = '0;
            v[7:0] = p;
            v[27:8] = s20;
            v[35:28] = c;
            v[36] = st;
            return v;
        end
    endfunction

    always_comb begin
        pos_next = pos_reg;
        phase_next = phase_reg;
        pnh_next = pnh_reg;
        ext_type_next = ext_type_reg;
        left_next = left_reg;
        start_next = start_reg;
        shift_next = shift_reg;
        count_next = count_reg;
        sent_next = sent_reg;
        n0 = 1'b0;
        n1 = 1'b0;
        r0 = '0;
        r1 = '0;
        nh = '0;
        walk = 1'b0;
        have = 1'b0;
        left_dec = '0;
        cnt_inc = (count_reg == 8'hFF) ? count_reg : count_reg + 8'd1;
        case (phase_reg)
            PH_FIXED: begin
                shift_next = {shift_reg[55:0], b};
                if (pos_reg[2:0] == 3'd7) begin
                    put(n0, n1, r0, r1, 3'(pos_reg >> 3), shift_next);
                    if (pos_reg == OFFSET_WIDTH'(7)) begin
                        pnh_next = shift_next[15:8];
                    end
                end
                if (pos_reg >= OFFSET_WIDTH'(39)) begin
                    start_next = OFFSET_WIDTH'(40);
                    have = 1'b1;
                end
            end
            PH_EXT0: begin
                shift_next = {56'd0, b};
                phase_next = PH_EXT1;
            end
            PH_EXT1: begin
                shift_next = {shift_reg[55:0], b};
                left_next = header_len(ext_type_reg, b) - 12'd2;
                phase_next = PH_BODY;
            end
            PH_BODY: begin
                if (ext_type_reg == T_FRAG) begin
                    shift_next = {shift_reg[55:0], b};
                end
                left_dec = (left_reg != 12'd0) ? left_reg - 12'd1 : left_reg;
                left_next = left_dec;
                if (left_dec == 12'd0) begin
                    if (ext_type_reg == T_FRAG) begin
                        nh = shift_next[63:56];
                        put(n0, n1, r0, r1, K_FRAG, {shift_next[63:56], 8'd0, shift_next[47:0]});
                    end else begin
                        nh = shift_next[15:8];
                        put(n0, n1, r0, r1, K_EXT,
                            {8'd0, 20'(start_reg),
                             header_len(ext_type_reg, shift_next[7:0]),
                             shift_next[7:0], nh, ext_type_reg});
                    end
                    count_next = cnt_inc;
                    pnh_next = nh;
                    start_next = pos_inc;
                    have = 1'b1;
                end
            end
            default: begin
            end
        endcase
        if (have) begin
            walk = (pnh_next == T_HOP) || (pnh_next == T_ROUTING) || (pnh_next == T_FRAG)
                || (pnh_next == T_AH) || (pnh_next == T_DEST);
            if (walk) begin
                ext_type_next = pnh_next;
                phase_next = PH_EXT0;
            end else begin
                phase_next = PH_PAYLOAD;
                put(n0, n1, r0, r1, K_SUMMARY, summ(pnh_next, start_next, count_next, 1'b0));
                sent_next = 1'b1;
            end
        end
        if (in_word.packet_end) begin
            if (!sent_next) begin
                put(n0, n1, r0, r1, K_SUMMARY, summ(pnh_next, start_next, count_next, 1'b1));
            end
            pos_next = '0;
            phase_next = PH_FIXED;
            pnh_next = '0;
            ext_type_next = '0;
            left_next = '0;
            start_next = '0;
            shift_next = '0;
            count_next = '0;
            sent_next = 1'b0;
        end else begin
            pos_next = pos_inc;
        end
        if (n1) begin
            r1.last_of_run = 1'b1;
        end else begin
            r0.last_of_run = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            phase_reg <= PH_FIXED;
            pnh_reg <= '0;
            ext_type_reg <= '0;
            left_reg <= '0;
            start_reg <= '0;
            shift_reg <= '0;
            count_reg <= '0;
            sent_reg <= 1'b0;
        end else if (take) begin
            pos_reg <= pos_next;
            phase_reg <= phase_next;
            pnh_reg <= pnh_next;
            ext_type_reg <= ext_type_next;
            left_reg <= left_next;
            start_reg <= start_next;
            shift_reg <= shift_next;
            count_reg <= count_next;
            sent_reg <= sent_next;
        end
    end

    assign job_valid = take && n0;
    assign job.two = n1;
    assign job.rec0 = r0;
    assign job.rec1 = r1;

endmodule

### hdl/ipv6hp_queue.sv
// ============================================================================
// ipv6hp_queue
// Small queue of per-byte record jobs between the front and the back.
// ============================================================================
module ipv6hp_queue
    import ipv6hp_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic wr_valid,
    input  job_t wr_job,
    output logic wr_ready,
    output logic rd_valid,
    output job_t rd_job,
    input  logic rd_ready
);

    job_t          mem_reg [QDEPTH];
    logic [QAW-1:0] wp_reg, rp_reg;
    logic [QAW:0]   cnt_reg;
    logic           push, pop;

    // front checks room ahead of the byte, so keep one slot spare
    assign wr_ready = cnt_reg < (QAW+1)'(QDEPTH - 1);
    assign rd_valid = cnt_reg != '0;
    assign rd_job = mem_reg[rp_reg];
    assign push = wr_valid;
    assign pop = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= wr_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop) begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (QAW+1)'(push) - (QAW+1)'(pop);
        end
    end

endmodule

### hdl/ipv6hp_back.sv
// ============================================================================
// ipv6hp_back
// Issues the one or two records of each job, one word per cycle while m_ready is high.
// ============================================================================
module ipv6hp_back
    import ipv6hp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      job_valid,
    input  job_t      job,
    output logic      job_ready,
    output logic      m_valid,
    output out_word_t m_data,
    input  logic      m_ready
);

    logic second_reg;

    assign m_valid = job_valid;
    assign m_data = second_reg ? job.rec1 : job.rec0;
    assign job_ready = m_ready && (second_reg || !job.two);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            second_reg <= 1'b0;
        end else if (job_valid && m_ready) begin
            second_reg <= !second_reg && job.two;
        end
    end

endmodule

### tb/sv/ipv6_header_chain_parser_top_tb.sv
// ============================================================================
// ipv6_header_chain_parser_top_tb
// Self-checking bench for the IPv6 header chain parser: packets are fed one
// byte per word, records are predicted by a local model and compared in order.
// ============================================================================
module ipv6_header_chain_parser_top_tb;
    import ipv6hp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int BYTES_PER_PHASE = 510;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;

    always #5 aclk = ~aclk;

    ipv6_header_chain_parser_top i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // parser state of the prediction
    logic [OFFSET_WIDTH-1:0] p_pos;
    phase_t                  p_phase;
    logic [7:0]              p_nh;
    logic [7:0]              p_type;
    logic [11:0]             p_left;
    logic [OFFSET_WIDTH-1:0] p_start;
    logic [63:0]             p_shift;
    logic [7:0]              p_count;
    logic                    p_done;

    out_word_t  expected_records[$];
    out_word_t  step_recs[$];
    int         errors = 0;
    int         n_bytes = 0;
    int         n_records = 0;
    int         n_packets = 0;
    int         idle_s_pct = 0;
    int         idle_m_pct = 0;
    int         stall_cnt = 0;

    function automatic logic is_walkable(input logic [7:0] t);
        return t == T_HOP || t == T_ROUTING || t == T_FRAG || t == T_AH || t == T_DEST;
    endfunction

    function automatic logic [11:0] span_bytes(input logic [7:0] t, input logic [7:0] len);
        if (t == T_FRAG) return 12'd8;
        if (t == T_AH) return ({4'd0, len} + 12'd2) * 12'd4;
        return ({4'd0, len} + 12'd1) * 12'd8;
    endfunction

    function automatic logic [OFFSET_WIDTH-1:0] sat_inc(input logic [OFFSET_WIDTH-1:0] v);
        return (v == OFF_MAX) ? v : v + 1'b1;
    endfunction

    task automatic push_rec(input logic [2:0] kind, input logic [63:0] value);
        out_word_t r;
        if (step_recs.size() < 2) begin
            r.record_kind = kind;
            r.record_value = value;
            r.last_of_run = 1'b0;
            step_recs.push_back(r);
        end
    endtask

    task automatic push_summary(input logic status);
        logic [63:0] v;
        v = '0;
        v[7:0] = p_nh;
        v[27:8] = 20'(p_start);
        v[35:28] = p_count;
        v[36] = status;
        push_rec(K_SUMMARY, v);
        p_done = 1'b1;
    endtask

    task automatic clear_parser();
        p_pos = '0; p_phase = PH_FIXED; p_nh = '0; p_type = '0; p_left = '0;
        p_start = '0; p_shift = '0; p_count = '0; p_done = 1'b0;
    endtask

    task automatic advance_chain();
        if (is_walkable(p_nh)) begin
            p_type = p_nh;
            p_phase = PH_EXT0;
        end else begin
            p_phase = PH_PAYLOAD;
            push_summary(1'b0);
        end
    endtask

    task automatic close_header();
        logic [7:0]  nh;
        logic [63:0] v;
        if (p_type == T_FRAG) begin
            nh = p_shift[63:56];
            v = p_shift;
            v[55:48] = 8'h00;
            push_rec(K_FRAG, v);
        end else begin
            nh = p_shift[15:8];
            v = '0;
            v[7:0] = p_type;
            v[15:8] = nh;
            v[23:16] = p_shift[7:0];
            v[35:24] = span_bytes(p_type, p_shift[7:0]);
            v[55:36] = 20'(p_start);
            push_rec(K_EXT, v);
        end
        if (p_count != 8'hff) p_count++;
        p_nh = nh;
        p_start = sat_inc(p_pos);
        advance_chain();
    endtask

    // works out the records one byte causes and appends them to expected_records
    task automatic predict_records(input in_word_t w);
        step_recs.delete();
        case (p_phase)
            PH_FIXED: begin
                p_shift = {p_shift[55:0], w.data_byte};
                if (p_pos[2:0] == 3'd7) begin
                    push_rec(3'(p_pos >> 3), p_shift);
                    if (p_pos == OFFSET_WIDTH'(7)) p_nh = p_shift[15:8];
                end
                if (p_pos >= OFFSET_WIDTH'(39)) begin
                    p_start = OFFSET_WIDTH'(40);
                    advance_chain();
                end
            end
            PH_EXT0: begin
                p_shift = {56'd0, w.data_byte};
                p_phase = PH_EXT1;
            end
            PH_EXT1: begin
                p_shift = {p_shift[55:0], w.data_byte};
                p_left = span_bytes(p_type, w.data_byte) - 12'd2;
                p_phase = PH_BODY;
            end
            PH_BODY: begin
                if (p_type == T_FRAG) p_shift = {p_shift[55:0], w.data_byte};
                if (p_left != 0) p_left--;
                if (p_left == 0) close_header();
            end
            default: ;
        endcase
        if (w.packet_end) begin
            if (!p_done) push_summary(1'b1);
            clear_parser();
        end else begin
            p_pos = sat_inc(p_pos);
        end
        if (step_recs.size() > 0) step_recs[step_recs.size()-1].last_of_run = 1'b1;
        foreach (step_recs[i]) expected_records.push_back(step_recs[i]);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        $display("mismatch: %s got %h want %h (record %0d)", what, got, want, n_records);
    endtask

    // directed words, with a typed-in check only where it is obvious
    typedef struct {
        in_word_t    w;
        logic        chk;
        out_word_t   want;
    } stim_row_t;

    stim_row_t dir_table[$];

    task automatic add_row(input logic [7:0] b, input logic e, input logic chk,
                           input logic [2:0] k, input logic [63:0] v);
        stim_row_t r;
        r.w.data_byte = b;
        r.w.packet_end = e;
        r.chk = chk;
        r.want.record_kind = k;
        r.want.record_value = v;
        r.want.last_of_run = 1'b1;
        dir_table.push_back(r);
    endtask

    // byte stream of the packet under construction
    logic [7:0] pkt[$];

    function automatic int walk_pick();
        case ($urandom_range(0, 4))
            0: return T_HOP;
            1: return T_ROUTING;
            2: return T_FRAG;
            3: return T_AH;
            default: return T_DEST;
        endcase
    endfunction

    task automatic build_packet(input bit wellformed);
        logic [7:0] nh, t, len;
        int hops, total;
        pkt.delete();
        nh = wellformed ? 8'(walk_pick()) : 8'($urandom);
        pkt.push_back(8'($urandom)); pkt.push_back(8'($urandom));
        pkt.push_back(8'($urandom)); pkt.push_back(8'($urandom));
        pkt.push_back(8'($urandom)); pkt.push_back(8'($urandom));
        pkt.push_back(nh); pkt.push_back(8'($urandom));
        for (int i = 0; i < 32; i++) pkt.push_back(8'($urandom));
        hops = $urandom_range(0, 5);
        t = nh;
        for (int h = 0; h < hops && is_walkable(t); h++) begin
            nh = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'(walk_pick());
            if (h == hops - 1 && $urandom_range(0, 1)) nh = 8'd50;
            len = ($urandom_range(0, 31) == 0) ? 8'($urandom) : 8'($urandom_range(0, 2));
            pkt.push_back(nh);
            pkt.push_back(len);
            total = int'(span_bytes(t, len));
            for (int i = 2; i < total; i++) pkt.push_back(8'($urandom));
            t = nh;
        end
        for (int i = $urandom_range(0, 6); i > 0; i--) pkt.push_back(8'($urandom));
        if (!wellformed) begin
            while (pkt.size() > 1 && $urandom_range(0, 1)) void'(pkt.pop_back());
        end
    endtask

    // valid stays up from one word to the next unless the sender idles
    task automatic send_word(input in_word_t w);
        while ($urandom_range(0, 99) < idle_s_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_data <= w;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_records(w);
        n_bytes++;
        @(negedge aclk);
    endtask

    task automatic send_packet();
        in_word_t w;
        foreach (pkt[i]) begin
            w.data_byte = pkt[i];
            w.packet_end = (i == pkt.size() - 1);
            send_word(w);
        end
        n_packets++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_records.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // receiver
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= idle_m_pct);
    end

    always @(posedge aclk) begin
        out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            n_records++;
            if (expected_records.size() == 0) begin
                report_mismatch("unexpected word", m_data.record_value, 64'd0);
            end else begin
                want = expected_records.pop_front();
                if (m_data.record_kind !== want.record_kind)
                    report_mismatch("record_kind", 64'(m_data.record_kind),
                                    64'(want.record_kind));
                if (m_data.record_value !== want.record_value)
                    report_mismatch("record_value", m_data.record_value, want.record_value);
                if (m_data.last_of_run !== want.last_of_run)
                    report_mismatch("last_of_run", 64'(m_data.last_of_run),
                                    64'(want.last_of_run));
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            stall_cnt <= 0;
        end else begin
            stall_cnt <= stall_cnt + 1;
            if (stall_cnt >= WATCHDOG_LIMIT) begin
                $display("watchdog expired, %0d words outstanding", expected_records.size());
                $display("[ipv6_header_chain_parser_top] ERROR");
                $finish;
            end
        end
    end

    initial begin
        out_word_t got;
        int        phase_end;
        clear_parser();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // single-byte packet: truncated summary, status bit set and all other fields zero
        add_row(8'hff, 1'b1, 1'b1, K_SUMMARY, 64'h10_0000_0000);
        // all-ones base word, next header 0xff is not walkable
        for (int i = 0; i < 7; i++) add_row(8'hff, 1'b0, 1'b0, '0, '0);
        add_row(8'hff, 1'b0, 1'b1, K_BASE, 64'hffff_ffff_ffff_ffff);
        for (int i = 0; i < 16; i++) add_row(8'h00, i == 15, 1'b0, '0, '0);

        idle_s_pct = 9;
        idle_m_pct = 85;
        foreach (dir_table[i]) begin
            send_word(dir_table[i].w);
            if (dir_table[i].chk) begin
                got = expected_records[expected_records.size()-1];
                if (got !== dir_table[i].want)
                    report_mismatch("directed row", got.record_value,
                                    dir_table[i].want.record_value);
            end
        end
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            idle_s_pct = (ph == 0) ? 9 : (ph == 1) ? 85 : 0;
            idle_m_pct = (ph == 0) ? 85 : (ph == 1) ? 9 : 0;
            phase_end = n_bytes + BYTES_PER_PHASE;
            while (n_bytes < phase_end) begin
                build_packet($urandom_range(0, 9) < 8);
                send_packet();
            end
            drain();
        end

        $display("covered %0d bytes in %0d packets, %0d records checked",
                 n_bytes, n_packets, n_records);
        if (errors == 0) begin
            $display("[ipv6_header_chain_parser_top] OK");
        end else begin
            $display("%0d mismatches", errors);
            $display("[ipv6_header_chain_parser_top] ERROR");
        end
        $finish;
    end

endmodule
